[rtl/isq_pkg.sv]
// ----------------------------------------------------------------------------
// isq_pkg
// Shared action codes for the interval set block.
// ----------------------------------------------------------------------------
package isq_pkg;

  typedef enum logic [2:0] {
    ACT_ADD      = 3'd0,
    ACT_ADD_OPEN = 3'd1,
    ACT_FINISH   = 3'd2,
    ACT_CONTAINS = 3'd3,
    ACT_NEXT     = 3'd4,
    ACT_CLEAR    = 3'd5
  } action_t;

endpackage

[rtl/isq_if.sv]
// ----------------------------------------------------------------------------
// isq_if
// Valid/ready channel interfaces for request and result transactions.
// ----------------------------------------------------------------------------
interface isq_in_if #(parameter int VALUE_BITS = 31);
  logic                  valid;
  logic                  ready;
  logic [2:0]            action;
  logic [VALUE_BITS-1:0] start_value;
  logic [VALUE_BITS-1:0] end_value;
  logic [VALUE_BITS-1:0] query_value;
  modport source (output valid, action, start_value, end_value, query_value, input ready);
  modport sink   (input valid, action, start_value, end_value, query_value, output ready);
endinterface

interface isq_out_if #(parameter int VALUE_BITS = 31, parameter int CNT_BITS = 7);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] next_value;
  logic [CNT_BITS-1:0]   entry_count;
  logic                  dropped;
  modport source (output valid, hit, next_value, entry_count, dropped, input ready);
  modport sink   (input valid, hit, next_value, entry_count, dropped, output ready);
endinterface

[rtl/isq_mem.sv]
// ----------------------------------------------------------------------------
// isq_mem
// Interval table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module isq_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 62
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/interval_set_merge_and_query_top.sv]
// ----------------------------------------------------------------------------
// interval_set_merge_and_query_top
// Table of half-open intervals with add, finish (sort and merge), queries.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake         | Payload
//  in_ch   | in  | valid/ready       | action, start_value, end_value, query_value
//  out_ch  | out | valid/ready       | hit, next_value, entry_count, dropped
//
// Add, add open-ended, clear and unused codes answer from the idle state,
// with the result valid in the cycle after acceptance. Contains and next
// scan the table through the memory read port. Finish runs an insertion
// sort on the table (one read, one write port), shifting larger entries up
// before each key, then a merge pass that writes back merged intervals.
// One transaction is in work at a time; a new one is taken once the result
// register is free or being emptied. Reset clears the entry count and the
// controller; the table holds no reset value.
// ----------------------------------------------------------------------------
module interval_set_merge_and_query_top #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_BITS  = 31
) (
  input logic      clk,
  input logic      rst_n,
  isq_in_if.sink   in_ch,
  isq_out_if.source out_ch
);
  import isq_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int VB = VALUE_BITS;
  localparam logic [VB-1:0] MAX_VALUE = {VB{1'b1}};
  localparam logic [CW-1:0] FULL_CNT  = CW'(TABLE_DEPTH);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_SKEY   = 10'b0000000010,
    ST_SKEYW  = 10'b0000000100,
    ST_SCMP   = 10'b0000001000,
    ST_SPUT   = 10'b0000010000,
    ST_MRD0   = 10'b0000100000,
    ST_MFIRST = 10'b0001000000,
    ST_MRD    = 10'b0010000000,
    ST_MCMP   = 10'b0100000000,
    ST_QSCAN  = 10'b1000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [CW-1:0]   w_r, w_nxt;
  logic            pend_r, pend_nxt;
  logic            is_next_r, is_next_nxt;
  logic [VB-1:0]   qv_r, qv_nxt;
  logic [VB-1:0]   key_s_r, key_s_nxt, key_e_r, key_e_nxt;
  logic [VB-1:0]   cur_s_r, cur_s_nxt, cur_e_r, cur_e_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            out_hit_r, out_hit_nxt;
  logic [VB-1:0]   out_next_r, out_next_nxt;
  logic            out_drop_r, out_drop_nxt;

  logic            wr_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [2*VB-1:0] wr_data, rd_data;
  logic [VB-1:0]   rd_s, rd_e;
  logic [CW-1:0]   jm1, jm2;
  logic            accept, key_before, q_match;
  logic [VB-1:0]   add_end;

  isq_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(2 * VB)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_s = rd_data[2*VB-1:VB];
  assign rd_e = rd_data[VB-1:0];
  assign jm1  = j_r - CW'(1);
  assign jm2  = j_r - CW'(2);

  // Take a new transaction only when idle and the result slot frees up.
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // Key sorts ahead of the element read from the table.
  assign key_before = (key_s_r != rd_s) ? (key_s_r < rd_s) : (key_e_r < rd_e);

  // Contains: qv in [s,e). Next: first entry whose end lies above qv.
  assign q_match = is_next_r ? (qv_r < rd_e) : ((qv_r >= rd_s) && (qv_r < rd_e));

  assign add_end = (in_ch.action == ACT_ADD) ? in_ch.end_value : MAX_VALUE;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    w_nxt         = w_r;
    pend_nxt      = pend_r;
    is_next_nxt   = is_next_r;
    qv_nxt        = qv_r;
    key_s_nxt     = key_s_r;
    key_e_nxt     = key_e_r;
    cur_s_nxt     = cur_s_r;
    cur_e_nxt     = cur_e_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_hit_nxt   = out_hit_r;
    out_next_nxt  = out_next_r;
    out_drop_nxt  = out_drop_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_addr       = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_hit_nxt  = 1'b0;
          out_next_nxt = '0;
          out_drop_nxt = 1'b0;
          case (in_ch.action)
            ACT_ADD, ACT_ADD_OPEN: begin
              out_valid_nxt = 1'b1;
              if (in_ch.start_value < add_end) begin
                if (count_r == FULL_CNT) begin
                  out_drop_nxt = 1'b1;
                end else begin
                  wr_en     = 1'b1;
                  wr_addr   = count_r[AW-1:0];
                  wr_data   = {in_ch.start_value, add_end};
                  count_nxt = count_r + CW'(1);
                end
              end
            end
            ACT_FINISH: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                i_nxt     = CW'(1);
                state_nxt = ST_SKEY;
              end
            end
            ACT_CONTAINS: begin
              is_next_nxt = 1'b0;
              qv_nxt      = in_ch.query_value;
              i_nxt       = '0;
              pend_nxt    = 1'b0;
              state_nxt   = ST_QSCAN;
            end
            ACT_NEXT: begin
              if (in_ch.query_value == MAX_VALUE) begin
                out_valid_nxt = 1'b1;
                out_next_nxt  = MAX_VALUE;
              end else begin
                is_next_nxt = 1'b1;
                qv_nxt      = in_ch.query_value + VB'(1);
                i_nxt       = '0;
                pend_nxt    = 1'b0;
                state_nxt   = ST_QSCAN;
              end
            end
            ACT_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      // Insertion sort: fetch the key at i.
      ST_SKEY: begin
        if (i_r >= count_r) begin
          state_nxt = ST_MRD0;
        end else begin
          rd_addr   = i_r[AW-1:0];
          j_nxt     = i_r;
          state_nxt = ST_SKEYW;
        end
      end
      ST_SKEYW: begin
        key_s_nxt = rd_s;
        key_e_nxt = rd_e;
        rd_addr   = jm1[AW-1:0];
        state_nxt = ST_SCMP;
      end
      // Shift the larger element up, or drop the key into its slot.
      ST_SCMP: begin
        wr_en   = 1'b1;
        wr_addr = j_r[AW-1:0];
        if (key_before) begin
          wr_data = rd_data;
          j_nxt   = jm1;
          if (jm1 != '0) begin
            rd_addr = jm2[AW-1:0];
          end else begin
            state_nxt = ST_SPUT;
          end
        end else begin
          wr_data   = {key_s_r, key_e_r};
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_SKEY;
        end
      end
      ST_SPUT: begin
        wr_en     = 1'b1;
        wr_addr   = j_r[AW-1:0];
        wr_data   = {key_s_r, key_e_r};
        i_nxt     = i_r + CW'(1);
        state_nxt = ST_SKEY;
      end
      // Merge pass: the open interval lives in cur_s/cur_e.
      ST_MRD0: begin
        rd_addr   = '0;
        state_nxt = ST_MFIRST;
      end
      ST_MFIRST: begin
        cur_s_nxt = rd_s;
        cur_e_nxt = rd_e;
        w_nxt     = '0;
        i_nxt     = CW'(1);
        state_nxt = ST_MRD;
      end
      ST_MRD: begin
        if (i_r >= count_r) begin
          wr_en         = 1'b1;
          wr_addr       = w_r[AW-1:0];
          wr_data       = {cur_s_r, cur_e_r};
          count_nxt     = w_r + CW'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          rd_addr   = i_r[AW-1:0];
          state_nxt = ST_MCMP;
        end
      end
      ST_MCMP: begin
        if (cur_e_r >= rd_s) begin
          if (cur_e_r < rd_e) begin
            cur_e_nxt = rd_e;
          end
        end else begin
          wr_en     = 1'b1;
          wr_addr   = w_r[AW-1:0];
          wr_data   = {cur_s_r, cur_e_r};
          w_nxt     = w_r + CW'(1);
          cur_s_nxt = rd_s;
          cur_e_nxt = rd_e;
        end
        i_nxt     = i_r + CW'(1);
        state_nxt = ST_MRD;
      end
      // Query scan: one read issued per cycle, checked once its registered data returns.
      ST_QSCAN: begin
        if (pend_r && q_match) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = !is_next_r;
          if (is_next_r) begin
            out_next_nxt = (qv_r >= rd_s) ? qv_r : rd_s;
          end
          state_nxt = ST_IDLE;
        end else if (i_r == count_r) begin
          out_valid_nxt = 1'b1;
          if (is_next_r) begin
            out_next_nxt = MAX_VALUE;
          end
          state_nxt = ST_IDLE;
        end else begin
          rd_addr  = i_r[AW-1:0];
          i_nxt    = i_r + CW'(1);
          pend_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the working registers; they need no reset.
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    w_r        <= w_nxt;
    pend_r     <= pend_nxt;
    is_next_r  <= is_next_nxt;
    qv_r       <= qv_nxt;
    key_s_r    <= key_s_nxt;
    key_e_r    <= key_e_nxt;
    cur_s_r    <= cur_s_nxt;
    cur_e_r    <= cur_e_nxt;
    out_hit_r  <= out_hit_nxt;
    out_next_r <= out_next_nxt;
    out_drop_r <= out_drop_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.next_value  = out_next_r;
  assign out_ch.entry_count = count_r;
  assign out_ch.dropped     = out_drop_r;

endmodule

[rtl/isq_checker.sv]
// ----------------------------------------------------------------------------
// isq_checker
// Port-level checks on the interval set block, bound to the top level.
// ----------------------------------------------------------------------------
module isq_checker #(
  parameter int DEPTH = 64,
  parameter int VB    = 31,
  parameter int CW    = 7
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic          hit,
  input logic [VB-1:0] next_value,
  input logic [CW-1:0] entry_count,
  input logic          dropped
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(next_value) && $stable(hit))
    else $error("result changed while stalled");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("transaction taken while result slot is held");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dropped |-> entry_count == CW'(DEPTH))
    else $error("drop reported on a table that is not full");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (next_value != '0) |-> !hit && !dropped)
    else $error("result mixes query kinds");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> entry_count <= CW'(DEPTH))
    else $error("entry count above table depth");

endmodule

bind interval_set_merge_and_query_top isq_checker #(
  .DEPTH (TABLE_DEPTH),
  .VB    (VALUE_BITS),
  .CW    ($clog2(TABLE_DEPTH + 1))
) u_isq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .hit         (out_ch.hit),
  .next_value  (out_ch.next_value),
  .entry_count (out_ch.entry_count),
  .dropped     (out_ch.dropped)
);
